### rtl/assert_macros.svh
// Assertion helpers shared by the RTL of the seat arbiter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/rnra_pkg.sv
// Types, codes and ring helpers for the ring neighbor resource arbiter.
// No dependencies.
`timescale 1ns / 1ps

package rnra_pkg;

    localparam int SEAT_W = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        ST_THINKING = 2'd0,
        ST_HUNGRY   = 2'd1,
        ST_EATING   = 2'd2
    } t_seat_st;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REQ,
        S_REL_L,
        S_REL_R
    } t_state;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic CFG_SEAT_COUNT = 1'b0;
    localparam logic CFG_HALTED     = 1'b1;

    // One write port and two read ports into the seat table.
    typedef struct packed {
        logic              we;
        logic [SEAT_W-1:0] wa;
        t_seat_st          wd;
        logic [SEAT_W-1:0] ra0;
        logic [SEAT_W-1:0] ra1;
    } t_mem_req;

    function automatic logic [CNT_W-1:0] left_of(input logic [CNT_W-1:0] s,
                                                 input logic [CNT_W-1:0] n);
        return (s == '0) ? n - CNT_W'(1) : s - CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] right_of(input logic [CNT_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
        return (s + CNT_W'(1) >= n) ? '0 : s + CNT_W'(1);
    endfunction

endpackage

### rtl/rnra_seat_mem.sv
// Seat state table: one write port, two registered read ports, write-first forwarding.
// Depends on rnra_pkg.
`timescale 1ns / 1ps

module rnra_seat_mem
    import rnra_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_seat_st o_rd0,
    output t_seat_st o_rd1
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_seat_st   r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_seat_st   r_rd0;
    t_seat_st   r_rd1;

    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] ra0;
    logic [ADDR_W-1:0] ra1;

    assign wa  = i_req.wa[ADDR_W-1:0];
    assign ra0 = i_req.ra0[ADDR_W-1:0];
    assign ra1 = i_req.ra1[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[wa] <= i_req.wd;
        end
    end

    // Unwritten entries read as thinking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && wa == ra0) begin
            r_rd0 <= i_req.wd;
        end else begin
            r_rd0 <= r_vld[ra0] ? r_mem[ra0] : ST_THINKING;
        end
        if (i_req.we && wa == ra1) begin
            r_rd1 <= i_req.wd;
        end else begin
            r_rd1 <= r_vld[ra1] ? r_mem[ra1] : ST_THINKING;
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

### rtl/rnra_ctrl.sv
// Sequencer for requests and releases: reads, decides and writes back seat states.
// Depends on rnra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rnra_ctrl
    import rnra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_func,
    input  logic [SEAT_W-1:0] i_seat,
    input  logic [CNT_W-1:0]  i_n,
    input  logic              i_halted,
    output logic              o_busy,
    output t_mem_req          o_mem,
    input  t_seat_st          i_rd0,
    input  t_seat_st          i_rd1,
    output logic              o_strobe,
    output logic [SEAT_W-1:0] o_target_seat,
    output logic              o_granted,
    output logic              o_ignored,
    output logic              o_last
);

    t_state            r_state, n_state;
    logic [SEAT_W-1:0] r_seat, n_seat;
    logic [SEAT_W-1:0] r_l, n_l;
    logic [SEAT_W-1:0] r_r, n_r;

    logic              r_strobe, n_strobe;
    logic [SEAT_W-1:0] r_tgt, n_tgt;
    logic              r_gnt, n_gnt;
    logic              r_ign, n_ign;
    logic              r_last, n_last;

    logic [CNT_W-1:0]  seat_x;
    logic [CNT_W-1:0]  l_x, rt_x, ll_x, rr_x;
    logic              drop;
    logic              grant;

    assign seat_x = {1'b0, i_seat};
    assign l_x    = left_of(seat_x, i_n);
    assign rt_x   = right_of(seat_x, i_n);
    assign ll_x   = left_of(l_x, i_n);
    assign rr_x   = right_of({1'b0, r_r}, i_n);
    assign drop   = (seat_x >= i_n) || (i_func == FUNC_REQUEST && i_halted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seat <= n_seat;
        r_l    <= n_l;
        r_r    <= n_r;
        r_tgt  <= n_tgt;
        r_gnt  <= n_gnt;
        r_ign  <= n_ign;
        r_last <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_seat   = r_seat;
        n_l      = r_l;
        n_r      = r_r;
        n_strobe = 1'b0;
        n_tgt    = r_tgt;
        n_gnt    = r_gnt;
        n_ign    = r_ign;
        n_last   = r_last;
        grant    = 1'b0;
        o_mem    = '{we: 1'b0, wa: r_seat, wd: ST_THINKING, ra0: r_l, ra1: r_r};

        unique case (r_state)
            S_IDLE: begin
                o_mem.wa = i_seat;
                if (i_accept) begin
                    n_seat = i_seat;
                    n_l    = l_x[SEAT_W-1:0];
                    n_r    = rt_x[SEAT_W-1:0];
                    if (drop) begin
                        n_strobe = 1'b1;
                        n_tgt    = i_seat;
                        n_gnt    = 1'b0;
                        n_ign    = 1'b1;
                        n_last   = 1'b1;
                    end else if (i_func == FUNC_REQUEST) begin
                        // Mark hungry now; neighbors come back next cycle.
                        o_mem.we  = 1'b1;
                        o_mem.wd  = ST_HUNGRY;
                        o_mem.ra0 = l_x[SEAT_W-1:0];
                        o_mem.ra1 = rt_x[SEAT_W-1:0];
                        n_state   = S_REQ;
                    end else begin
                        // Release: seat to thinking, fetch left and its left.
                        o_mem.we  = 1'b1;
                        o_mem.wd  = ST_THINKING;
                        o_mem.ra0 = l_x[SEAT_W-1:0];
                        o_mem.ra1 = ll_x[SEAT_W-1:0];
                        n_state   = S_REL_L;
                    end
                end
            end
            S_REQ: begin
                grant    = (i_rd0 != ST_EATING) && (i_rd1 != ST_EATING);
                o_mem.we = 1'b1;
                o_mem.wa = r_seat;
                o_mem.wd = grant ? ST_EATING : ST_HUNGRY;
                n_strobe = 1'b1;
                n_tgt    = r_seat;
                n_gnt    = grant;
                n_ign    = 1'b0;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_REL_L: begin
                // Right of the left neighbor is the releasing seat, now thinking.
                grant     = (i_rd0 == ST_HUNGRY) && (i_rd1 != ST_EATING);
                o_mem.we  = grant;
                o_mem.wa  = r_l;
                o_mem.wd  = ST_EATING;
                o_mem.ra0 = r_r;
                o_mem.ra1 = rr_x[SEAT_W-1:0];
                n_strobe  = 1'b1;
                n_tgt     = r_l;
                n_gnt     = grant;
                n_ign     = 1'b0;
                n_last    = 1'b0;
                n_state   = S_REL_R;
            end
            S_REL_R: begin
                grant    = (i_rd0 == ST_HUNGRY) && (i_rd1 != ST_EATING);
                o_mem.we = grant;
                o_mem.wa = r_r;
                o_mem.wd = ST_EATING;
                n_strobe = 1'b1;
                n_tgt    = r_r;
                n_gnt    = grant;
                n_ign    = 1'b0;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_target_seat = r_tgt;
    assign o_granted     = r_gnt;
    assign o_ignored     = r_ign;
    assign o_last        = r_last;

    `ASSERT_NEXT(a_rel_ends, i_clk, i_rst_n, r_state == S_REL_R, o_strobe && o_last)
    `ASSERT_NEXT(a_rel_first, i_clk, i_rst_n, r_state == S_REL_L, o_strobe && !o_last && !o_ignored)
    `ASSERT_IMP(a_drop_clean, i_clk, i_rst_n, o_strobe && o_ignored, !o_granted && o_last)

endmodule

### rtl/ring_neighbor_resource_arbiter.sv
// Top level of the ring neighbor resource arbiter: configuration registers,
// effective seat count, sequencer and seat table. Depends on rnra_pkg, rnra_ctrl and rnra_seat_mem.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive i_func (0 request, 1 release) and i_seat with start
//   high; the item is taken at a clock edge where start is high and busy low.
//   Result channel: each result shows on o_target_seat, o_granted, o_ignored
//   and o_last for exactly one cycle with o_strobe high. The receiver cannot
//   stall; results must be taken when shown.
//   Results: a dropped item gives its result from S_IDLE, where it is taken; a
//   request gives its result from S_REQ, once the neighbor reads return; a
//   release gives its left result from S_REL_L, then its right from S_REL_R.
//   A dropped item leaves the block idle; a request or release holds busy
//   high until its last result, and no new item is taken before then. The
//   seat table sets this pace: one write port, two registered read ports, so
//   each neighbor check is a read then a write-back in the following cycle.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 seat
//   count, 1 halted); the user must write only while the block is idle, which the block does not enforce.
//   Reset: synchronous, active low; all seats thinking, seat count 5,
//   not halted. Table entries read as thinking until first written, so
//   no clearing pass is needed.
module ring_neighbor_resource_arbiter
    import rnra_pkg::*;
#(
    parameter int MAX_SEATS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [SEAT_W-1:0] i_seat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [SEAT_W-1:0] o_target_seat,
    output logic              o_granted,
    output logic              o_ignored,
    output logic              o_last
);

    // Seats beyond what the seat field can address are never used.
    localparam int               DEPTH = (MAX_SEATS < 16) ? MAX_SEATS : 16;
    localparam logic [CNT_W-1:0] LIM   = CNT_W'(DEPTH);

    logic [CNT_W-1:0] r_seat_count;
    logic             r_halted;
    logic [CNT_W-1:0] eff_n;
    logic             accept;
    t_mem_req         mem_req;
    t_seat_st         rd0;
    t_seat_st         rd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= CNT_W'(5);
            r_halted     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEAT_COUNT: r_seat_count <= i_cfg_wdata;
                CFG_HALTED:     r_halted     <= i_cfg_wdata[0];
                default:        r_halted     <= r_halted;
            endcase
        end
    end

    // Clamp the count into one .. table depth; zero acts as one.
    always_comb begin
        priority if (r_seat_count == '0) begin
            eff_n = CNT_W'(1);
        end else if (r_seat_count > LIM) begin
            eff_n = LIM;
        end else begin
            eff_n = r_seat_count;
        end
    end

    assign accept = start && !busy;

    rnra_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_seat        (i_seat),
        .i_n           (eff_n),
        .i_halted      (r_halted),
        .o_busy        (busy),
        .o_mem         (mem_req),
        .i_rd0         (rd0),
        .i_rd1         (rd1),
        .o_strobe      (o_strobe),
        .o_target_seat (o_target_seat),
        .o_granted     (o_granted),
        .o_ignored     (o_ignored),
        .o_last        (o_last)
    );

    rnra_seat_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd0   (rd0),
        .o_rd1   (rd1)
    );

endmodule
